// ----- rtl/rdm_drd_pkg.sv -----
// Shared types and constants for the RDM discovery reply decoder.
// No dependencies; imported by rdm_discovery_reply_decoder_unit.
`default_nettype none

package rdm_drd_pkg;

    localparam int unsigned POS_W = 5;

    localparam logic [7:0] PREAMBLE_BYTE  = 8'hFE;
    localparam logic [7:0] SEPARATOR_BYTE = 8'hAA;

    // Frame layout, as byte positions
    localparam logic [POS_W-1:0] PREAMBLE_BYTES = 5'd7;   // bytes 0..6
    localparam logic [POS_W-1:0] SEPARATOR_POS  = 5'd7;
    localparam logic [POS_W-1:0] UID_END        = 5'd20;  // encoded UID is bytes 8..19
    localparam logic [POS_W-1:0] FRAME_BYTES    = 5'd24;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_PREAMBLE  = 3'd2,
        STATUS_SEPARATOR = 3'd3,
        STATUS_CHECKSUM  = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/rdm_discovery_reply_decoder_unit.sv -----
// RDM discovery-unique-branch reply decoder, top level.
// Depends on rdm_drd_pkg.
`default_nettype none

// Decodes an RDM discovery reply streamed one byte per transfer, with
// frame_end marking the last byte. Bytes 0-6 must be 0xFE and byte 7 0xAA;
// bytes 8-19 are ANDed in pairs into the 48-bit UID (MSB first) and bytes
// 20-23 into the received checksum, which is checked against the 16-bit
// wrapping sum of bytes 8-19. Bytes beyond the 24th are dropped. One result
// transfer comes out per frame_end byte: reply_ok, status (ok, too short,
// bad preamble, bad separator, checksum mismatch, in that priority) and the
// UID, which reads zero unless the status is ok. Bytes that are not the end
// of a frame produce no result. Rate: one byte per clock, sustained while
// in_ready stays high. A byte is captured in an input register; from there
// it updates the frame state, and a frame_end byte also loads a result into
// the output register. in_ready drops only when an end-of-frame byte sits in
// the input register while the output register holds a result that the
// consumer has not taken; the output register is the only place a result
// waits, so back-pressure reaches the input after one held byte. All frame
// state returns to zero after each frame_end byte.
module rdm_discovery_reply_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte stream
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_end,
    // decode results
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             reply_ok,
    output logic [2:0]       status,
    output logic [15:0]      uid_manufacturer,
    output logic [31:0]      uid_device
);
    import rdm_drd_pkg::*;

    // ---------------- input register ----------------
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       byte_reg;
    logic             end_reg;
    logic             s1_take;     // input register hands its byte on
    logic             res_load;    // output register takes a new result

    // ---------------- frame state ----------------
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             pre_err_reg, pre_err_next;
    logic             sep_err_reg, sep_err_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       first_reg, first_next;
    logic [47:0]      uid_reg, uid_next;
    logic [15:0]      rx_csum_reg, rx_csum_next;

    // ---------------- output register ----------------
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [47:0]      uid_out_reg, uid_out_next;

    // Upd byte goes on unless it ends a frame while a result is still held.
    assign s1_take  = in_valid_reg && (!end_reg || !out_valid_reg || out_ready);
    assign res_load = s1_take && end_reg;
    assign in_ready = !in_valid_reg || s1_take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
            end_reg  <= frame_end;
        end
    end

    // Frame state update for the byte in the input register. The status
    // is judged on the state including this byte.
    logic [POS_W-1:0] upd_pos;
    logic             upd_pre_err;
    logic             upd_sep_err;
    logic [15:0]      upd_sum;
    logic [7:0]       upd_first;
    logic [47:0]      upd_uid;
    logic [15:0]      upd_rx_csum;

    always_comb
    begin
        upd_pos     = pos_reg;
        upd_pre_err = pre_err_reg;
        upd_sep_err = sep_err_reg;
        upd_sum     = sum_reg;
        upd_first   = first_reg;
        upd_uid     = uid_reg;
        upd_rx_csum = rx_csum_reg;

        if (pos_reg < FRAME_BYTES)
        begin
            upd_pos = pos_reg + 5'd1;
            if (pos_reg < PREAMBLE_BYTES)
            begin
                if (byte_reg != PREAMBLE_BYTE)
                begin
                    upd_pre_err = 1'b1;
                end
            end
            else if (pos_reg == SEPARATOR_POS)
            begin
                if (byte_reg != SEPARATOR_BYTE)
                begin
                    upd_sep_err = 1'b1;
                end
            end
            else
            begin
                if (pos_reg < UID_END)
                begin
                    upd_sum = sum_reg + {8'h00, byte_reg};
                end
                // even position opens a pair, odd position closes it
                if (!pos_reg[0])
                begin
                    upd_first = byte_reg;
                end
                else if (pos_reg < UID_END)
                begin
                    upd_uid = {uid_reg[39:0], first_reg & byte_reg};
                end
                else
                begin
                    upd_rx_csum = {rx_csum_reg[7:0], first_reg & byte_reg};
                end
            end
        end
    end

    always_comb
    begin
        if (upd_pos < FRAME_BYTES)
        begin
            status_next = STATUS_SHORT;
        end
        else if (upd_pre_err)
        begin
            status_next = STATUS_PREAMBLE;
        end
        else if (upd_sep_err)
        begin
            status_next = STATUS_SEPARATOR;
        end
        else if (upd_rx_csum != upd_sum)
        begin
            status_next = STATUS_CHECKSUM;
        end
        else
        begin
            status_next = STATUS_OK;
        end
        uid_out_next = (status_next == STATUS_OK) ? upd_uid : 48'h0;
    end

    // Frame end clears the state for the next frame.
    always_comb
    begin
        pos_next     = pos_reg;
        pre_err_next = pre_err_reg;
        sep_err_next = sep_err_reg;
        sum_next     = sum_reg;
        first_next   = first_reg;
        uid_next     = uid_reg;
        rx_csum_next = rx_csum_reg;
        if (res_load)
        begin
            pos_next     = '0;
            pre_err_next = 1'b0;
            sep_err_next = 1'b0;
            sum_next     = '0;
            first_next   = '0;
            uid_next     = '0;
            rx_csum_next = '0;
        end
        else if (s1_take)
        begin
            pos_next     = upd_pos;
            pre_err_next = upd_pre_err;
            sep_err_next = upd_sep_err;
            sum_next     = upd_sum;
            first_next   = upd_first;
            uid_next     = upd_uid;
            rx_csum_next = upd_rx_csum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            pre_err_reg <= 1'b0;
            sep_err_reg <= 1'b0;
            sum_reg     <= '0;
            first_reg   <= '0;
            uid_reg     <= '0;
            rx_csum_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            pre_err_reg <= pre_err_next;
            sep_err_reg <= sep_err_next;
            sum_reg     <= sum_next;
            first_reg   <= first_next;
            uid_reg     <= uid_next;
            rx_csum_reg <= rx_csum_next;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg  <= status_next;
            uid_out_reg <= uid_out_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign reply_ok         = (status_reg == STATUS_OK);
    assign uid_manufacturer = uid_out_reg[47:32];
    assign uid_device       = uid_out_reg[31:0];

`ifndef ASSERT_OFF
    // position never runs past the frame length
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= FRAME_BYTES)
        else $error("byte position beyond frame length");

    // an end-of-frame byte resets the frame state
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (pos_reg == '0 && !pre_err_reg && !sep_err_reg && sum_reg == '0))
        else $error("frame state not cleared after frame end");

    // a failed decode never reports a UID
    a_uid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_OK) |-> (uid_out_reg == '0))
        else $error("UID reported on failed decode");

    // stall only with an end byte waiting behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && end_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a held result");

    // a held result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !res_load)
        else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

// ----- tb/rdm_discovery_reply_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rdm_discovery_reply_decoder_unit.
// Depends on rdm_drd_pkg and the decoder RTL; a scoreboard class predicts each reply.

import rdm_drd_pkg::*;

// Tracks the frame the way the decoder should, queues one expected reply per
// frame_end byte, and compares each reply transfer with the oldest one.
class discovery_reply_checker;
    typedef struct {
        logic        ok;
        status_t     st;
        logic [15:0] manu;
        logic [31:0] dev;
    } reply_t;

    reply_t      pending_replies[$];
    int unsigned errors;

    logic [POS_W-1:0] pos;
    logic             preamble_bad;
    logic             separator_bad;
    logic [15:0]      byte_sum;
    logic [7:0]       pair_lead;
    logic [47:0]      uid_acc;
    logic [15:0]      csum_acc;

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        pos           = '0;
        preamble_bad  = 1'b0;
        separator_bad = 1'b0;
        byte_sum      = '0;
        pair_lead     = '0;
        uid_acc       = '0;
        csum_acc      = '0;
    endfunction

    function int outstanding();
        return pending_replies.size();
    endfunction

    // One accepted input transfer.
    function void take_byte(logic [7:0] b, logic last);
        reply_t r;
        if (pos < FRAME_BYTES) begin
            if (pos < PREAMBLE_BYTES) begin
                if (b != PREAMBLE_BYTE)
                    preamble_bad = 1'b1;
            end
            else if (pos == SEPARATOR_POS) begin
                if (b != SEPARATOR_BYTE)
                    separator_bad = 1'b1;
            end
            else if (pos < UID_END) begin
                byte_sum = byte_sum + 16'(b);
                if (!pos[0])
                    pair_lead = b;
                else
                    uid_acc = {uid_acc[39:0], pair_lead & b};
            end
            else begin
                if (!pos[0])
                    pair_lead = b;
                else
                    csum_acc = {csum_acc[7:0], pair_lead & b};
            end
            pos = pos + 1'b1;
        end
        if (last) begin
            if (pos < FRAME_BYTES)
                r.st = STATUS_SHORT;
            else if (preamble_bad)
                r.st = STATUS_PREAMBLE;
            else if (separator_bad)
                r.st = STATUS_SEPARATOR;
            else if (csum_acc != byte_sum)
                r.st = STATUS_CHECKSUM;
            else
                r.st = STATUS_OK;
            r.ok   = (r.st == STATUS_OK);
            r.manu = r.ok ? uid_acc[47:32] : 16'h0;
            r.dev  = r.ok ? uid_acc[31:0] : 32'h0;
            pending_replies.push_back(r);
            clear();
        end
    endfunction

    function void report(string what, logic [47:0] want, logic [47:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // One accepted result transfer.
    function void check_reply(logic ok, logic [2:0] st, logic [15:0] manu, logic [31:0] dev);
        reply_t r;
        if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected reply, expected none, actual status %0h uid %0h_%0h",
                     $time, st, manu, dev);
            return;
        end
        r = pending_replies.pop_front();
        if (ok !== r.ok)
            report("reply_ok", 48'(r.ok), 48'(ok));
        if (st !== r.st)
            report("status", 48'(r.st), 48'(st));
        if (manu !== r.manu)
            report("uid_manufacturer", 48'(r.manu), 48'(manu));
        if (dev !== r.dev)
            report("uid_device", 48'(r.dev), 48'(dev));
    endfunction
endclass

module rdm_discovery_reply_decoder_unit_tb;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_PREAMBLE,
        FRAME_BAD_SEPARATOR,
        FRAME_BAD_SUM,
        FRAME_SHORT,
        FRAME_LONG,
        FRAME_NOISE
    } frame_kind_t;

    localparam int RANDOM_BYTES = 1900;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the pipe

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    logic        reply_ok;
    logic [2:0]  status;
    logic [15:0] uid_manufacturer;
    logic [31:0] uid_device;

    discovery_reply_checker chk;

    // Shared between the stimulus process and the receiver process
    bit          idle_en;     // random idle bursts allowed
    bit          hold_req;    // ask the receiver for one long hold-off

    logic [7:0]  frame_bytes[$];
    int          bytes_sent;

    rdm_discovery_reply_decoder_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .frame_end        (frame_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .reply_ok         (reply_ok),
        .status           (status),
        .uid_manufacturer (uid_manufacturer),
        .uid_device       (uid_device)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Fills frame_bytes with one frame of the given kind. A well-formed frame
    // encodes each UID byte u as the pair (u|m, u|~m) with a random mask m,
    // so the bytes of a pair vary with m but still AND back to u.
    task automatic build_frame(frame_kind_t kind, logic [47:0] id);
        logic [15:0] sum;
        logic [15:0] cs;
        logic [7:0]  u;
        logic [7:0]  m;
        int          k;
        int          len;
        frame_bytes.delete();
        repeat (7)
            frame_bytes.push_back(PREAMBLE_BYTE);
        frame_bytes.push_back(SEPARATOR_BYTE);
        sum = '0;
        for (k = 5; k >= 0; k--)
        begin
            u = id[k*8 +: 8];
            m = 8'($urandom_range(0, 255));
            frame_bytes.push_back(u | m);
            frame_bytes.push_back(u | ~m);
            sum = sum + 16'(u | m) + 16'(u | ~m);
        end
        cs = sum;
        if (kind == FRAME_BAD_SUM)
            cs = cs ^ (16'd1 << $urandom_range(0, 15));
        for (k = 1; k >= 0; k--)
        begin
            u = cs[k*8 +: 8];
            m = 8'($urandom_range(0, 255));
            frame_bytes.push_back(u | m);
            frame_bytes.push_back(u | ~m);
        end
        case (kind)
            FRAME_BAD_PREAMBLE:
            begin
                k = $urandom_range(0, 6);
                frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
            end
            FRAME_BAD_SEPARATOR:
                frame_bytes[7] = frame_bytes[7] ^ 8'($urandom_range(1, 255));
            FRAME_SHORT:
            begin
                len = $urandom_range(1, 23);
                while (frame_bytes.size() > len)
                    void'(frame_bytes.pop_back());
            end
            FRAME_LONG:
                repeat ($urandom_range(1, 8))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            FRAME_NOISE:
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 30))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
                ;
        endcase
    endtask

    // Offers one byte and returns at the falling edge after its transfer.
    // The caller's next action sets in_valid at that same falling edge.
    task automatic send_byte(logic [7:0] b, logic last);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(negedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        frame_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chk.take_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Receiver: ready/stall runs, random stall bursts, and one long hold-off
    // on request while the sender keeps pushing.
    initial
    begin
        int n;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 12);
            end
            else
            begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 30);
            end
            repeat (n - 1)
                @(negedge clk);
        end
    end

    // Result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            chk.check_reply(reply_ok, status, uid_manufacturer, uid_device);
    end

    // Main stimulus
    initial
    begin
        int   pick;
        bit   hold_done;
        bit   pause_done;
        chk        = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        frame_end  = 1'b0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed frames ----
        // UID extremes, all zero and all ones
        build_frame(FRAME_GOOD, 48'h0);
        send_frame();
        build_frame(FRAME_GOOD, 48'hFFFF_FFFF_FFFF);
        send_frame();
        // each fault on its own
        build_frame(FRAME_BAD_PREAMBLE, 48'h1234_5678_9ABC);
        send_frame();
        build_frame(FRAME_BAD_SEPARATOR, 48'h1234_5678_9ABC);
        send_frame();
        build_frame(FRAME_BAD_SUM, 48'hFEDC_BA98_7654);
        send_frame();
        // preamble fault outranks separator fault
        build_frame(FRAME_BAD_SEPARATOR, 48'h0102_0304_0506);
        frame_bytes[0] = 8'h00;
        send_frame();
        // separator fault outranks checksum mismatch
        build_frame(FRAME_BAD_SUM, 48'hA5A5_5A5A_A5A5);
        frame_bytes[7] = 8'hFF;
        send_frame();
        // single-byte frame
        frame_bytes.delete();
        frame_bytes.push_back(8'hFF);
        send_frame();
        // 23 bytes: too short wins over a bad preamble
        build_frame(FRAME_GOOD, 48'h8000_0000_0001);
        frame_bytes[3] = 8'h00;
        void'(frame_bytes.pop_back());
        send_frame();
        // long frames: trailing bytes are dropped
        build_frame(FRAME_LONG, 48'h7FFF_8000_0001);
        send_frame();
        build_frame(FRAME_BAD_SUM, 48'h0000_FFFF_0000);
        repeat (6)
            frame_bytes.push_back(8'hFF);
        send_frame();

        // ---- random frames, mostly well-formed ----
        while (bytes_sent < RANDOM_BYTES)
        begin
            // receiver holds off while the sender keeps going
            if (!hold_done && bytes_sent >= 500)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            // sender pauses until the decoder has drained
            if (!pause_done && bytes_sent >= 1100)
            begin
                in_valid <= 1'b0;
                while (chk.outstanding() != 0)
                    @(negedge clk);
                repeat (20)
                    @(negedge clk);
                pause_done = 1'b1;
            end
            // full-rate tail with no idling on either side
            if (bytes_sent >= 1500)
                idle_en = 1'b0;

            pick = $urandom_range(0, 99);
            if (pick < 55)
                build_frame(FRAME_GOOD, {16'($urandom), 32'($urandom)});
            else if (pick < 63)
                build_frame(FRAME_BAD_PREAMBLE, {16'($urandom), 32'($urandom)});
            else if (pick < 71)
                build_frame(FRAME_BAD_SEPARATOR, {16'($urandom), 32'($urandom)});
            else if (pick < 79)
                build_frame(FRAME_BAD_SUM, {16'($urandom), 32'($urandom)});
            else if (pick < 87)
                build_frame(FRAME_SHORT, {16'($urandom), 32'($urandom)});
            else if (pick < 95)
                build_frame(FRAME_LONG, {16'($urandom), 32'($urandom)});
            else
                build_frame(FRAME_NOISE, 48'h0);
            send_frame();
        end
        in_valid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (chk.outstanding() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
        if (chk.errors == 0 && chk.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
